FILE: sv/crtp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crtp_pkg;

    // Field and register widths.
    localparam int ROW_CNT_W = 21;
    localparam int COL_CNT_W = 15;
    localparam int ROW_ACC_W = 22;
    localparam int COL_ACC_W = 16;
    localparam int ROW_OUT_W = 20;
    localparam int COL_OUT_W = 14;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 21;

    typedef logic [ROW_CNT_W-1:0] row_cnt_t;
    typedef logic [COL_CNT_W-1:0] col_cnt_t;
    typedef logic [ROW_ACC_W-1:0] row_acc_t;
    typedef logic [COL_ACC_W-1:0] col_acc_t;

    // Accumulator saturation points and number bases.
    localparam col_acc_t COL_SAT = 16'hFFFF;
    localparam row_acc_t ROW_SAT = 22'h3FFFFF;
    localparam int COL_RADIX = 26;
    localparam int ROW_RADIX = 10;

    // Character codes.
    localparam logic [7:0] CHR_TAB     = 8'h09;
    localparam logic [7:0] CHR_CR      = 8'h0D;
    localparam logic [7:0] CHR_SPACE   = 8'h20;
    localparam logic [7:0] CHR_NEL     = 8'h85;
    localparam logic [7:0] CHR_NBSP    = 8'hA0;
    localparam logic [7:0] CHR_COMMA   = 8'h2C;
    localparam logic [7:0] CHR_COLON   = 8'h3A;
    localparam logic [7:0] CHR_ZERO    = 8'h30;
    localparam logic [7:0] CHR_NINE    = 8'h39;
    localparam logic [7:0] CHR_UPPER_A = 8'h41;
    localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHR_LOWER_A = 8'h61;
    localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_GAP    = 8'h20;

    // Queue between the parser front and the result back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT = 1'b0,
        CFG_COL_COUNT = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        CH_WS,
        CH_COLON,
        CH_COMMA,
        CH_LETTER,
        CH_DIGIT,
        CH_OTHER
    } char_class_t;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_LET,
        PH_DIG,
        PH_TRAIL
    } phase_t;

    typedef enum logic [2:0] {
        KIND_INVALID,
        KIND_CELL,
        KIND_COLS,
        KIND_ROWS,
        KIND_FULL
    } kind_t;

    // One input beat.
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } in_t;

    // One result beat.
    typedef struct packed {
        logic                 range_valid;
        logic [ROW_OUT_W-1:0] top_row;
        logic [COL_OUT_W-1:0] left_col;
        logic [ROW_OUT_W-1:0] bottom_row;
        logic [COL_OUT_W-1:0] right_col;
        logic                 text_done;
    } out_t;

    // Finished token as classified by the front, queued for the back end.
    typedef struct packed {
        kind_t    kind;
        col_acc_t c1;
        row_acc_t r1;
        col_acc_t c2;
        row_acc_t r2;
        logic     done;
    } rec_t;

    // Effective sheet size after limiting by the build maxima.
    typedef struct packed {
        row_cnt_t rows;
        col_cnt_t cols;
    } sheet_size_t;

endpackage

`default_nettype wire

FILE: sv/crtp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module crtp_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    input  crtp_pkg::in_t       in_data,
    output logic                in_stall,
    input  wire logic           queue_full,
    output logic                push,
    output crtp_pkg::rec_t      push_data
);

    localparam int COL_MAC_W = 21;
    localparam int ROW_MAC_W = 26;

    // Token state apart from the phase.
    typedef struct packed {
        logic               has_let;
        logic               has_dig;
        logic               has_colon;
        logic               has_err;
        logic               has_content;
        crtp_pkg::col_acc_t c1;
        crtp_pkg::row_acc_t r1;
        crtp_pkg::col_acc_t c2;
        crtp_pkg::row_acc_t r2;
    } tok_t;

    crtp_pkg::phase_t      phase_reg;
    crtp_pkg::phase_t      phase_next;
    tok_t                  tok_reg;
    tok_t                  tok_next;
    tok_t                  tok_upd;
    tok_t                  tok_fin;
    crtp_pkg::char_class_t cls;
    logic                  accept;
    logic                  eot;
    logic [7:0]            upper_code;
    logic [4:0]            let_val;
    logic [3:0]            dig_val;
    crtp_pkg::col_acc_t    cacc_cur;
    crtp_pkg::row_acc_t    racc_cur;
    logic [COL_MAC_W-1:0]  col_mac;
    logic [ROW_MAC_W-1:0]  row_mac;
    crtp_pkg::col_acc_t    col_new;
    crtp_pkg::row_acc_t    row_new;

    // A half is bad when it is empty or its row number is zero.
    function automatic logic half_bad(input tok_t t);
        crtp_pkg::row_acc_t row;
        row = t.has_colon ? t.r2 : t.r1;
        return !(t.has_let || t.has_dig) || (t.has_dig && row == '0);
    endfunction

    // Sorts a finished token into one of the accepted shapes.
    function automatic crtp_pkg::kind_t classify(input tok_t t);
        logic ac;
        logic ar;
        logic bc;
        logic br;
        crtp_pkg::kind_t k;
        ac = t.c1 != '0;
        ar = t.r1 != '0;
        bc = t.c2 != '0;
        br = t.r2 != '0;
        k  = crtp_pkg::KIND_INVALID;
        if (t.has_content && !t.has_err && !half_bad(t))
        begin
            if (!t.has_colon)
            begin
                if (ac && ar)
                    k = crtp_pkg::KIND_CELL;
            end
            else if (ac && bc && !ar && !br)
                k = crtp_pkg::KIND_COLS;
            else if (ar && br && !ac && !bc)
                k = crtp_pkg::KIND_ROWS;
            else if (ac && ar && bc && br)
                k = crtp_pkg::KIND_FULL;
        end
        return k;
    endfunction

    // Handshake on the character channel.
    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign eot      = in_data.end_of_text;

    // Character decoder.
    always_comb
    begin
        unique case (in_data.char_code) inside
            crtp_pkg::CHR_COMMA:
                cls = crtp_pkg::CH_COMMA;
            crtp_pkg::CHR_COLON:
                cls = crtp_pkg::CH_COLON;
            [crtp_pkg::CHR_TAB:crtp_pkg::CHR_CR], crtp_pkg::CHR_SPACE,
            crtp_pkg::CHR_NEL, crtp_pkg::CHR_NBSP:
                cls = crtp_pkg::CH_WS;
            [crtp_pkg::CHR_UPPER_A:crtp_pkg::CHR_UPPER_Z],
            [crtp_pkg::CHR_LOWER_A:crtp_pkg::CHR_LOWER_Z]:
                cls = crtp_pkg::CH_LETTER;
            [crtp_pkg::CHR_ZERO:crtp_pkg::CHR_NINE]:
                cls = crtp_pkg::CH_DIGIT;
            default:
                cls = crtp_pkg::CH_OTHER;
        endcase
    end

    // Letter and digit values.
    always_comb
    begin
        upper_code = (in_data.char_code >= crtp_pkg::CHR_LOWER_A)
                   ? in_data.char_code - crtp_pkg::CASE_GAP : in_data.char_code;
        let_val    = 5'(upper_code - crtp_pkg::CHR_UPPER_A + 8'd1);
        dig_val    = 4'(in_data.char_code - crtp_pkg::CHR_ZERO);
    end

    // Multiply-add of the current half's accumulators, with saturation.
    always_comb
    begin
        cacc_cur = tok_reg.has_colon ? tok_reg.c2 : tok_reg.c1;
        racc_cur = tok_reg.has_colon ? tok_reg.r2 : tok_reg.r1;
        col_mac  = COL_MAC_W'(cacc_cur) * COL_MAC_W'(crtp_pkg::COL_RADIX)
                 + COL_MAC_W'(let_val);
        row_mac  = ROW_MAC_W'(racc_cur) * ROW_MAC_W'(crtp_pkg::ROW_RADIX)
                 + ROW_MAC_W'(dig_val);
        col_new  = (col_mac > COL_MAC_W'(crtp_pkg::COL_SAT))
                 ? crtp_pkg::COL_SAT : col_mac[crtp_pkg::COL_ACC_W-1:0];
        row_new  = (row_mac > ROW_MAC_W'(crtp_pkg::ROW_SAT))
                 ? crtp_pkg::ROW_SAT : row_mac[crtp_pkg::ROW_ACC_W-1:0];
    end

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (cls == crtp_pkg::CH_COMMA || eot)
                phase_next = crtp_pkg::PH_LEAD;
            else
            begin
                unique case (cls)
                    crtp_pkg::CH_WS:
                        if (phase_reg == crtp_pkg::PH_LET || phase_reg == crtp_pkg::PH_DIG)
                            phase_next = crtp_pkg::PH_TRAIL;
                    crtp_pkg::CH_COLON:
                        if (!tok_reg.has_colon)
                            phase_next = crtp_pkg::PH_LEAD;
                    crtp_pkg::CH_LETTER:
                        if (phase_reg == crtp_pkg::PH_LEAD || phase_reg == crtp_pkg::PH_LET)
                            phase_next = crtp_pkg::PH_LET;
                    crtp_pkg::CH_DIGIT:
                        if (phase_reg != crtp_pkg::PH_TRAIL)
                            phase_next = crtp_pkg::PH_DIG;
                    default:
                        phase_next = phase_reg;
                endcase
            end
        end
    end

    // Token update for any character but a comma.
    always_comb
    begin
        tok_upd = tok_reg;
        case (cls)
            crtp_pkg::CH_COLON:
            begin
                tok_upd.has_content = 1'b1;
                if (tok_reg.has_colon)
                    tok_upd.has_err = 1'b1;
                else
                begin
                    if (half_bad(tok_reg))
                        tok_upd.has_err = 1'b1;
                    tok_upd.has_let   = 1'b0;
                    tok_upd.has_dig   = 1'b0;
                    tok_upd.has_colon = 1'b1;
                end
            end
            crtp_pkg::CH_LETTER:
            begin
                tok_upd.has_content = 1'b1;
                if (phase_reg == crtp_pkg::PH_LEAD || phase_reg == crtp_pkg::PH_LET)
                begin
                    tok_upd.has_let = 1'b1;
                    if (tok_reg.has_colon)
                        tok_upd.c2 = col_new;
                    else
                        tok_upd.c1 = col_new;
                end
                else
                    tok_upd.has_err = 1'b1;
            end
            crtp_pkg::CH_DIGIT:
            begin
                tok_upd.has_content = 1'b1;
                if (phase_reg != crtp_pkg::PH_TRAIL)
                begin
                    tok_upd.has_dig = 1'b1;
                    if (tok_reg.has_colon)
                        tok_upd.r2 = row_new;
                    else
                        tok_upd.r1 = row_new;
                end
                else
                    tok_upd.has_err = 1'b1;
            end
            crtp_pkg::CH_OTHER:
            begin
                tok_upd.has_content = 1'b1;
                tok_upd.has_err     = 1'b1;
            end
            default:
                tok_upd = tok_reg;
        endcase
    end

    // Next token state: cleared when a token ends.
    always_comb
    begin
        tok_next = tok_reg;
        if (accept)
            tok_next = (cls == crtp_pkg::CH_COMMA || eot) ? '0 : tok_upd;
    end

    // Finished token record. A comma finishes the token as it stood before it.
    always_comb
    begin
        tok_fin          = (cls == crtp_pkg::CH_COMMA) ? tok_reg : tok_upd;
        push_data.kind   = classify(tok_fin);
        push_data.c1     = tok_fin.c1;
        push_data.r1     = tok_fin.r1;
        push_data.c2     = tok_fin.c2;
        push_data.r2     = tok_fin.r2;
        push_data.done   = eot;
        if (cls == crtp_pkg::CH_COMMA)
            push = accept && (tok_reg.has_content || eot);
        else
            push = accept && eot;
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= crtp_pkg::PH_LEAD;
            tok_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            tok_reg   <= tok_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/crtp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module crtp_queue (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  crtp_pkg::rec_t push_data,
    output logic           full,
    input  wire logic      pop,
    output logic           head_valid,
    output crtp_pkg::rec_t head_data
);

    crtp_pkg::rec_t                      entry_reg [crtp_pkg::QUEUE_DEPTH];
    logic [crtp_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg;
    logic [crtp_pkg::QUEUE_PTR_W-1:0]    wr_ptr_next;
    logic [crtp_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg;
    logic [crtp_pkg::QUEUE_PTR_W-1:0]    rd_ptr_next;
    logic [crtp_pkg::QUEUE_CNT_W-1:0]    count_reg;
    logic [crtp_pkg::QUEUE_CNT_W-1:0]    count_next;

    // Status and head of the queue.
    assign full       = count_reg == crtp_pkg::QUEUE_CNT_W'(crtp_pkg::QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = entry_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= crtp_pkg::QUEUE_CNT_W'(crtp_pkg::QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("token pushed into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("token popped from an empty queue");
`endif

endmodule

`default_nettype wire

FILE: sv/crtp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module crtp_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  crtp_pkg::sheet_size_t size,
    input  wire logic           head_valid,
    input  crtp_pkg::rec_t      head_data,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_stall,
    output crtp_pkg::out_t      out_data
);

    crtp_pkg::row_cnt_t rmax;
    crtp_pkg::col_cnt_t cmax;
    crtp_pkg::row_acc_t r1z;
    crtp_pkg::row_acc_t r2z;
    crtp_pkg::col_acc_t c1z;
    crtp_pkg::col_acc_t c2z;
    crtp_pkg::row_acc_t t_raw;
    crtp_pkg::row_acc_t b_raw;
    crtp_pkg::col_acc_t l_raw;
    crtp_pkg::col_acc_t r_raw;
    logic               ok;

    // Clamp stage registers.
    logic               a_valid_reg;
    logic               a_ok_reg;
    logic               a_done_reg;
    crtp_pkg::row_cnt_t a_top_reg;
    crtp_pkg::row_cnt_t a_bot_reg;
    crtp_pkg::col_cnt_t a_left_reg;
    crtp_pkg::col_cnt_t a_right_reg;

    // Output register.
    logic               out_valid_reg;
    crtp_pkg::out_t     out_data_reg;
    crtp_pkg::out_t     out_data_next;

    logic               a_load;
    logic               b_load;

    // Flow control through both stages.
    assign b_load = a_valid_reg && (!out_valid_reg || !out_stall);
    assign a_load = head_valid && (!a_valid_reg || b_load);
    assign pop    = a_load;

    // Zero-based corners chosen by token shape.
    always_comb
    begin
        rmax  = size.rows - 1'b1;
        cmax  = size.cols - 1'b1;
        r1z   = head_data.r1 - 1'b1;
        r2z   = head_data.r2 - 1'b1;
        c1z   = head_data.c1 - 1'b1;
        c2z   = head_data.c2 - 1'b1;
        t_raw = '0;
        b_raw = '0;
        l_raw = '0;
        r_raw = '0;
        case (head_data.kind)
            crtp_pkg::KIND_CELL:
            begin
                t_raw = r1z;
                b_raw = r1z;
                l_raw = c1z;
                r_raw = c1z;
            end
            crtp_pkg::KIND_COLS:
            begin
                b_raw = crtp_pkg::ROW_ACC_W'(rmax);
                l_raw = c1z;
                r_raw = c2z;
            end
            crtp_pkg::KIND_ROWS:
            begin
                t_raw = r1z;
                b_raw = r2z;
                r_raw = crtp_pkg::COL_ACC_W'(cmax);
            end
            crtp_pkg::KIND_FULL:
            begin
                t_raw = r1z;
                b_raw = r2z;
                l_raw = c1z;
                r_raw = c2z;
            end
            default:
                t_raw = '0;
        endcase
        ok = head_data.kind != crtp_pkg::KIND_INVALID
          && size.rows != '0 && size.cols != '0;
    end

    // Clamp stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (a_load)
            a_valid_reg <= 1'b1;
        else if (b_load)
            a_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_ok_reg   <= ok;
            a_done_reg <= head_data.done;
            if (!ok)
            begin
                a_top_reg   <= '0;
                a_bot_reg   <= '0;
                a_left_reg  <= '0;
                a_right_reg <= '0;
            end
            else
            begin
                a_top_reg   <= (t_raw > crtp_pkg::ROW_ACC_W'(rmax))
                             ? rmax : t_raw[crtp_pkg::ROW_CNT_W-1:0];
                a_bot_reg   <= (b_raw > crtp_pkg::ROW_ACC_W'(rmax))
                             ? rmax : b_raw[crtp_pkg::ROW_CNT_W-1:0];
                a_left_reg  <= (l_raw > crtp_pkg::COL_ACC_W'(cmax))
                             ? cmax : l_raw[crtp_pkg::COL_CNT_W-1:0];
                a_right_reg <= (r_raw > crtp_pkg::COL_ACC_W'(cmax))
                             ? cmax : r_raw[crtp_pkg::COL_CNT_W-1:0];
            end
        end
    end

    // Swap into order, then cut to the output widths.
    always_comb
    begin
        out_data_next.range_valid = a_ok_reg;
        out_data_next.text_done   = a_done_reg;
        if (a_top_reg > a_bot_reg)
        begin
            out_data_next.top_row    = a_bot_reg[crtp_pkg::ROW_OUT_W-1:0];
            out_data_next.bottom_row = a_top_reg[crtp_pkg::ROW_OUT_W-1:0];
        end
        else
        begin
            out_data_next.top_row    = a_top_reg[crtp_pkg::ROW_OUT_W-1:0];
            out_data_next.bottom_row = a_bot_reg[crtp_pkg::ROW_OUT_W-1:0];
        end
        if (a_left_reg > a_right_reg)
        begin
            out_data_next.left_col  = a_right_reg[crtp_pkg::COL_OUT_W-1:0];
            out_data_next.right_col = a_left_reg[crtp_pkg::COL_OUT_W-1:0];
        end
        else
        begin
            out_data_next.left_col  = a_left_reg[crtp_pkg::COL_OUT_W-1:0];
            out_data_next.right_col = a_right_reg[crtp_pkg::COL_OUT_W-1:0];
        end
    end

    // Output stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (b_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (b_load)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_data_reg.range_valid) |->
        (out_data_reg.top_row == '0 && out_data_reg.bottom_row == '0
         && out_data_reg.left_col == '0 && out_data_reg.right_col == '0))
        else $error("invalid range carries non-zero corners");
`endif

endmodule

`default_nettype wire

FILE: sv/cell_range_text_parser.sv
// Range text parser: reads comma-separated spreadsheet ranges (A1, A1:B3,
// A:C, 1:3) one character per beat and gives one result beat per token.
// Text channel: text_valid / text_stall / text_data, one character a beat,
// with end_of_text marking the last one. Result channel: result_valid /
// result_stall / result_data, with the range flag, the four zero-based
// corners and text_done. Configuration channel: cfg_valid / cfg_ready with
// cfg_index 0 for the row count and 1 for the column count; cfg_ready is
// always high. The user must make writes only while the block is idle; the
// block does not enforce this. Throughput: one character a cycle unless the
// queue is full, set by the combinational multiply-add and state update of
// the front parser. A token result goes from the beat that ends it (a comma
// or the last character) through a four-entry queue, a clamp stage and a
// swap/output register. When the result side stalls, results wait in the
// output register, the clamp stage and the queue; the text channel stalls
// only when the queue is full. Reset clears the parser state, the queue and
// both stages and sets the sheet size to its full default; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module cell_range_text_parser #(
    parameter int unsigned MAX_ROWS = 1048576,
    parameter int unsigned MAX_COLS = 16384
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            text_valid,
    output logic                                 text_stall,
    input  crtp_pkg::in_t                        text_data,
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output crtp_pkg::out_t                       result_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [crtp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [crtp_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam crtp_pkg::row_cnt_t ROW_COUNT_RST = 21'd1048576;
    localparam crtp_pkg::col_cnt_t COL_COUNT_RST = 15'd16384;

    crtp_pkg::row_cnt_t    row_count_reg;
    crtp_pkg::col_cnt_t    col_count_reg;
    crtp_pkg::sheet_size_t size_reg;
    crtp_pkg::sheet_size_t size_next;
    logic                  queue_full;
    logic                  push;
    crtp_pkg::rec_t        push_data;
    logic                  pop;
    logic                  head_valid;
    crtp_pkg::rec_t        head_data;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ROW_COUNT_RST;
            col_count_reg <= COL_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (crtp_pkg::cfg_reg_t'(cfg_index))
                crtp_pkg::CFG_ROW_COUNT:
                    row_count_reg <= cfg_data[crtp_pkg::ROW_CNT_W-1:0];
                crtp_pkg::CFG_COL_COUNT:
                    col_count_reg <= cfg_data[crtp_pkg::COL_CNT_W-1:0];
                default:
                    row_count_reg <= row_count_reg;
            endcase
        end
    end

    // Effective sheet size, limited by the build maxima and registered.
    always_comb
    begin
        if (32'(row_count_reg) < MAX_ROWS)
            size_next.rows = row_count_reg;
        else
            size_next.rows = crtp_pkg::row_cnt_t'(MAX_ROWS);
        if (32'(col_count_reg) < MAX_COLS)
            size_next.cols = col_count_reg;
        else
            size_next.cols = crtp_pkg::col_cnt_t'(MAX_COLS);
    end

    always_ff @(posedge clk)
    begin
        size_reg <= size_next;
    end

    crtp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (text_valid),
        .in_data    (text_data),
        .in_stall   (text_stall),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    crtp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    crtp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .size       (size_reg),
        .head_valid (head_valid),
        .head_data  (head_data),
        .pop        (pop),
        .out_valid  (result_valid),
        .out_stall  (result_stall),
        .out_data   (result_data)
    );

endmodule

`default_nettype wire

FILE: dv/tb_cell_range_text_parser.sv
`timescale 1ns / 1ps

module tb_cell_range_text_parser;

    import crtp_pkg::*;

    localparam int unsigned SHEET_ROWS_MAX = 1048576;
    localparam int unsigned SHEET_COLS_MAX = 16384;

    localparam int unsigned RESET_CYCLES     = 10;
    localparam int unsigned SETTLE_CYCLES    = 8;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT      = 500000;

    // Idle styles for either side of the block.
    localparam int unsigned IDLE_NONE  = 0;
    localparam int unsigned IDLE_SOME  = 1;
    localparam int unsigned IDLE_HEAVY = 2;

    // Kinds of one half of a range token.
    localparam int unsigned HALF_CELL = 0;
    localparam int unsigned HALF_COL  = 1;
    localparam int unsigned HALF_ROW  = 2;

    // Sheet sizes walked through after the directed part; the last one is random.
    localparam int NUM_PHASES      = 7;
    localparam int PRESSURE_PHASE  = 4;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int unsigned PHASE_ROWS [NUM_PHASES-1] = '{1, 2097151, 0, 1048576, 50, 1048575};
    localparam int unsigned PHASE_COLS [NUM_PHASES-1] = '{1, 32767, 16384, 0, 20, 16383};

    // Directed table: one text beat per row, with a result typed in where it is obvious.
    typedef struct packed {
        in_t  beat;
        logic has_want;
        out_t want;
    } dir_row_t;

    localparam out_t NO_WANT        = '0;
    localparam out_t BAD_RANGE      = '0;
    localparam out_t ORIGIN_CELL    = '{1'b1, 20'd0, 14'd0, 20'd0, 14'd0, 1'b0};
    localparam out_t CLAMPED_CORNER = '{1'b1, 20'd8, 14'd16383, 20'd8, 14'd16383, 1'b0};
    localparam out_t EMPTY_END      = '{1'b0, 20'd0, 14'd0, 20'd0, 14'd0, 1'b1};

    localparam int DIR_LEN = 22;
    localparam dir_row_t DIRECTED [DIR_LEN] = '{
        // A1 is the top left cell.
        '{'{"A", 1'b0}, 1'b0, NO_WANT},
        '{'{"1", 1'b0}, 1'b0, NO_WANT},
        '{'{CHR_COMMA, 1'b0}, 1'b1, ORIGIN_CELL},
        // Whole columns, lower case, reversed and with a trailing blank.
        '{'{"c", 1'b0}, 1'b0, NO_WANT},
        '{'{CHR_COLON, 1'b0}, 1'b0, NO_WANT},
        '{'{"A", 1'b0}, 1'b0, NO_WANT},
        '{'{CHR_SPACE, 1'b0}, 1'b0, NO_WANT},
        '{'{CHR_COMMA, 1'b0}, 1'b0, NO_WANT},
        // Whole rows, reversed.
        '{'{"3", 1'b0}, 1'b0, NO_WANT},
        '{'{CHR_COLON, 1'b0}, 1'b0, NO_WANT},
        '{'{"1", 1'b0}, 1'b0, NO_WANT},
        '{'{CHR_COMMA, 1'b0}, 1'b0, NO_WANT},
        // Letters after digits spoil the token.
        '{'{"1", 1'b0}, 1'b0, NO_WANT},
        '{'{"a", 1'b0}, 1'b0, NO_WANT},
        '{'{CHR_COMMA, 1'b0}, 1'b1, BAD_RANGE},
        // An empty token gives nothing.
        '{'{CHR_COMMA, 1'b0}, 1'b0, NO_WANT},
        // Column beyond the sheet is clamped to the last one.
        '{'{"Z", 1'b0}, 1'b0, NO_WANT},
        '{'{"Z", 1'b0}, 1'b0, NO_WANT},
        '{'{"Z", 1'b0}, 1'b0, NO_WANT},
        '{'{"9", 1'b0}, 1'b0, NO_WANT},
        '{'{CHR_COMMA, 1'b0}, 1'b1, CLAMPED_CORNER},
        // Blank final token still closes the text.
        '{'{CHR_TAB, 1'b1}, 1'b1, EMPTY_END}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  text_valid = 1'b0;
    logic                  text_stall;
    in_t                   text_data = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    out_t                  result_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor copy of the sheet size and the token being parsed.
    row_cnt_t sheet_rows = 21'd1048576;
    col_cnt_t sheet_cols = 15'd16384;
    phase_t   tok_phase = PH_LEAD;
    col_acc_t col_a = '0;
    row_acc_t row_a = '0;
    col_acc_t col_b = '0;
    row_acc_t row_b = '0;
    logic     seen_letters = 1'b0;
    logic     seen_digits = 1'b0;
    logic     seen_colon = 1'b0;
    logic     bad_token = 1'b0;
    logic     seen_content = 1'b0;

    out_t        expected_ranges[$];
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned rx_mode = IDLE_HEAVY;
    logic        hold_request = 1'b0;

    cell_range_text_parser #(
        .MAX_ROWS(SHEET_ROWS_MAX),
        .MAX_COLS(SHEET_COLS_MAX)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .text_valid(text_valid),
        .text_stall(text_stall),
        .text_data(text_data),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_data(result_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic void clear_token();
        tok_phase = PH_LEAD;
        col_a = '0;
        row_a = '0;
        col_b = '0;
        row_b = '0;
        seen_letters = 1'b0;
        seen_digits = 1'b0;
        seen_colon = 1'b0;
        bad_token = 1'b0;
        seen_content = 1'b0;
    endfunction

    // A half must hold letters or digits, and a row number may not be zero.
    function automatic void close_half();
        row_acc_t row;
        row = seen_colon ? row_b : row_a;
        if (!seen_letters && !seen_digits)
            bad_token = 1'b1;
        if (seen_digits && row == 0)
            bad_token = 1'b1;
    endfunction

    // Range for the token that ends now: kind check, clamp to the sheet, then order.
    function automatic out_t finish_token(logic done);
        int unsigned rows, cols, t, l, b, r, swap;
        logic ok, ac, ar, bc, br;
        out_t res;
        rows = (sheet_rows < SHEET_ROWS_MAX) ? sheet_rows : SHEET_ROWS_MAX;
        cols = (sheet_cols < SHEET_COLS_MAX) ? sheet_cols : SHEET_COLS_MAX;
        ok = 1'b0;
        t = 0;
        l = 0;
        b = 0;
        r = 0;
        if (seen_content)
        begin
            close_half();
            if (!bad_token && rows != 0 && cols != 0)
            begin
                ac = (col_a != 0);
                ar = (row_a != 0);
                bc = (col_b != 0);
                br = (row_b != 0);
                if (!seen_colon)
                begin
                    if (ac && ar)
                    begin
                        ok = 1'b1;
                        t = row_a - 1;
                        b = t;
                        l = col_a - 1;
                        r = l;
                    end
                end
                else if (ac && bc && !ar && !br)
                begin
                    ok = 1'b1;
                    b = rows - 1;
                    l = col_a - 1;
                    r = col_b - 1;
                end
                else if (ar && br && !ac && !bc)
                begin
                    ok = 1'b1;
                    r = cols - 1;
                    t = row_a - 1;
                    b = row_b - 1;
                end
                else if (ac && ar && bc && br)
                begin
                    ok = 1'b1;
                    t = row_a - 1;
                    l = col_a - 1;
                    b = row_b - 1;
                    r = col_b - 1;
                end
                if (ok)
                begin
                    if (t > rows - 1) t = rows - 1;
                    if (b > rows - 1) b = rows - 1;
                    if (l > cols - 1) l = cols - 1;
                    if (r > cols - 1) r = cols - 1;
                    if (t > b)
                    begin
                        swap = t;
                        t = b;
                        b = swap;
                    end
                    if (l > r)
                    begin
                        swap = l;
                        l = r;
                        r = swap;
                    end
                end
            end
        end
        res = '0;
        if (ok)
        begin
            res.range_valid = 1'b1;
            res.top_row = ROW_OUT_W'(t);
            res.left_col = COL_OUT_W'(l);
            res.bottom_row = ROW_OUT_W'(b);
            res.right_col = COL_OUT_W'(r);
        end
        res.text_done = done;
        return res;
    endfunction

    // Advances the parser copy by one accepted character and queues any result.
    function automatic void take_char(in_t beat);
        logic [7:0] c;
        logic [7:0] up;
        logic second;
        int unsigned x;
        c = beat.char_code;
        second = seen_colon;
        if (c == CHR_COMMA)
        begin
            if (seen_content || beat.end_of_text)
                expected_ranges.push_back(finish_token(beat.end_of_text));
            clear_token();
            return;
        end
        if ((c >= CHR_TAB && c <= CHR_CR) || c == CHR_SPACE || c == CHR_NEL || c == CHR_NBSP)
        begin
            if (tok_phase == PH_LET || tok_phase == PH_DIG)
                tok_phase = PH_TRAIL;
        end
        else
        begin
            seen_content = 1'b1;
            if (c == CHR_COLON)
            begin
                if (second)
                    bad_token = 1'b1;
                else
                begin
                    close_half();
                    seen_letters = 1'b0;
                    seen_digits = 1'b0;
                    seen_colon = 1'b1;
                    tok_phase = PH_LEAD;
                end
            end
            else if ((c >= CHR_UPPER_A && c <= CHR_UPPER_Z) ||
                     (c >= CHR_LOWER_A && c <= CHR_LOWER_Z))
            begin
                up = (c >= CHR_LOWER_A) ? c - CASE_GAP : c;
                if (tok_phase == PH_LEAD || tok_phase == PH_LET)
                begin
                    x = (second ? col_b : col_a) * COL_RADIX + (up - CHR_UPPER_A + 1);
                    if (x > COL_SAT)
                        x = COL_SAT;
                    if (second)
                        col_b = col_acc_t'(x);
                    else
                        col_a = col_acc_t'(x);
                    tok_phase = PH_LET;
                    seen_letters = 1'b1;
                end
                else
                    bad_token = 1'b1;
            end
            else if (c >= CHR_ZERO && c <= CHR_NINE)
            begin
                if (tok_phase != PH_TRAIL)
                begin
                    x = (second ? row_b : row_a) * ROW_RADIX + (c - CHR_ZERO);
                    if (x > ROW_SAT)
                        x = ROW_SAT;
                    if (second)
                        row_b = row_acc_t'(x);
                    else
                        row_a = row_acc_t'(x);
                    tok_phase = PH_DIG;
                    seen_digits = 1'b1;
                end
                else
                    bad_token = 1'b1;
            end
            else
                bad_token = 1'b1;
        end
        if (beat.end_of_text)
        begin
            expected_ranges.push_back(finish_token(1'b1));
            clear_token();
        end
    endfunction

    function automatic int unsigned draw_wait(int unsigned mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0;
            default: return $urandom_range(0, 14);
        endcase
    endfunction

    function automatic logic [7:0] blank_char();
        int unsigned pick;
        pick = $urandom_range(0, 7);
        if (pick < 5)
            return CHR_TAB + 8'(pick);
        else if (pick == 5)
            return CHR_SPACE;
        else if (pick == 6)
            return CHR_NEL;
        return CHR_NBSP;
    endfunction

    function automatic void put_blanks(ref logic [7:0] q[$]);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) q.push_back(blank_char());
    endfunction

    // Mostly short column names, now and then long enough to saturate.
    function automatic void put_letters(ref logic [7:0] q[$]);
        int unsigned roll, len;
        roll = $urandom_range(0, 19);
        len = (roll < 12) ? 1 : (roll < 17) ? 2 : (roll < 19) ? 3 : $urandom_range(4, 5);
        repeat (len)
            q.push_back(($urandom_range(0, 1) ? CHR_UPPER_A : CHR_LOWER_A) +
                        8'($urandom_range(0, 25)));
    endfunction

    // Mostly short row numbers, sometimes past the sheet or the accumulator.
    function automatic void put_digits(ref logic [7:0] q[$]);
        int unsigned roll, len;
        int k;
        roll = $urandom_range(0, 19);
        len = (roll < 10) ? 1 : (roll < 15) ? 2 : (roll < 18) ? 3 : $urandom_range(5, 8);
        for (k = 0; k < len; k++)
        begin
            if (k == 0 && $urandom_range(0, 15) != 0)
                q.push_back(CHR_ZERO + 8'($urandom_range(1, 9)));
            else
                q.push_back(CHR_ZERO + 8'($urandom_range(0, 9)));
        end
    endfunction

    function automatic void put_half(ref logic [7:0] q[$], input int unsigned kind);
        put_blanks(q);
        if (kind != HALF_ROW)
            put_letters(q);
        if (kind != HALF_COL)
            put_digits(q);
        put_blanks(q);
    endfunction

    function automatic void put_pair(ref logic [7:0] q[$], input int unsigned first_kind,
                                     input int unsigned second_kind);
        put_half(q, first_kind);
        q.push_back(CHR_COLON);
        put_half(q, second_kind);
    endfunction

    // Offers one text beat after the given gap and waits until it is taken.
    task automatic send_beat(input in_t beat, input int unsigned gap);
        if (gap != 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_valid <= 1'b1;
        text_data  <= beat;
        @(posedge clk);
        while (text_stall) @(posedge clk);
        take_char(beat);
    endtask

    // Stops sending and lets every outstanding result drain.
    task automatic wait_idle();
        text_valid <= 1'b0;
        while (expected_ranges.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_ROW_COUNT)
            sheet_rows = row_cnt_t'(value);
        else
            sheet_cols = col_cnt_t'(value);
        @(posedge clk);
    endtask

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Result side: checks each beat, then stalls for a drawn number of cycles.
    initial
    begin : result_sink
        int unsigned hold_left;
        out_t want;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                if (expected_ranges.size() == 0)
                begin
                    $display("%0t: result beat expected none, actual %h", $time, result_data);
                    fail_count++;
                end
                else
                begin
                    want = expected_ranges.pop_front();
                    compare_field("range_valid", want.range_valid, result_data.range_valid);
                    compare_field("top_row", want.top_row, result_data.top_row);
                    compare_field("left_col", want.left_col, result_data.left_col);
                    compare_field("bottom_row", want.bottom_row, result_data.bottom_row);
                    compare_field("right_col", want.right_col, result_data.right_col);
                    compare_field("text_done", want.text_done, result_data.text_done);
                end
                hold_left = draw_wait(rx_mode);
            end
            if (hold_request)
            begin
                hold_request <= 1'b0;
                hold_left = LONG_HOLD_CYCLES;
            end
            result_stall <= (hold_left != 0);
            if (hold_left != 0)
                hold_left--;
        end
    end

    initial
    begin : stimulus
        logic [7:0] text[$];
        logic [7:0] odd;
        in_t beat;
        int unsigned rows_set, cols_set, sent, n_tok, pick, start, tx_mode;
        int i, k, p;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset sheet size.
        for (i = 0; i < DIR_LEN; i++)
        begin
            send_beat(DIRECTED[i].beat, draw_wait(IDLE_HEAVY));
            if (DIRECTED[i].has_want)
                expected_ranges[expected_ranges.size() - 1] = DIRECTED[i].want;
        end

        for (p = 0; p < NUM_PHASES; p++)
        begin
            if (p == NUM_PHASES - 1)
            begin
                rows_set = $urandom_range(1, 2097151);
                cols_set = $urandom_range(1, 32767);
            end
            else
            begin
                rows_set = PHASE_ROWS[p];
                cols_set = PHASE_COLS[p];
            end
            wait_idle();
            write_reg(CFG_ROW_COUNT, rows_set);
            write_reg(CFG_COL_COUNT, cols_set);
            // Hold the result side back while text keeps coming, to fill the queue.
            if (p == PRESSURE_PHASE)
                hold_request <= 1'b1;

            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                // Build one text of a few comma-separated tokens.
                text.delete();
                n_tok = $urandom_range(1, 6);
                for (k = 0; k < n_tok; k++)
                begin
                    if (k != 0)
                        text.push_back(CHR_COMMA);
                    pick = $urandom_range(0, 99);
                    start = text.size();
                    if (pick >= 90)
                    begin
                        repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
                    end
                    else if (pick >= 82)
                    begin
                        put_blanks(text);
                    end
                    else
                    begin
                        case (pick % 5)
                            0: put_half(text, ($urandom_range(0, 9) == 0) ?
                                              $urandom_range(HALF_COL, HALF_ROW) : HALF_CELL);
                            1: put_pair(text, HALF_CELL, HALF_CELL);
                            2: put_pair(text, HALF_COL, HALF_COL);
                            3: put_pair(text, HALF_ROW, HALF_ROW);
                            default: put_pair(text, $urandom_range(HALF_CELL, HALF_ROW),
                                              $urandom_range(HALF_CELL, HALF_ROW));
                        endcase
                        // Some well-formed tokens get one stray character somewhere.
                        if (pick >= 62)
                        begin
                            case ($urandom_range(0, 5))
                                0: odd = 8'($urandom_range(0, 255));
                                1: odd = CHR_COLON;
                                2: odd = blank_char();
                                3: odd = $urandom_range(0, 1) ? "+" : "-";
                                4: odd = CHR_UPPER_A + 8'($urandom_range(0, 25));
                                default: odd = CHR_ZERO + 8'($urandom_range(0, 9));
                            endcase
                            text.insert($urandom_range(start, text.size()), odd);
                        end
                    end
                end
                if (text.size() == 0 || $urandom_range(0, 7) == 0)
                    text.push_back(CHR_COMMA);

                tx_mode = (p == PRESSURE_PHASE) ? IDLE_NONE : $urandom_range(0, 2);
                rx_mode = (p == PRESSURE_PHASE) ? IDLE_NONE : $urandom_range(0, 2);
                foreach (text[j])
                begin
                    beat.char_code = text[j];
                    beat.end_of_text = (j == text.size() - 1);
                    send_beat(beat, draw_wait(tx_mode));
                end
                sent += text.size();
            end
        end

        wait_idle();
        if (fail_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/crtp_pkg.sv
sv/crtp_front.sv
sv/crtp_queue.sv
sv/crtp_back.sv
sv/cell_range_text_parser.sv
dv/tb_cell_range_text_parser.sv
